FILE: hdl/cbm_pkg.sv
// Shared types, constants and helpers for the compressed bitmap AND/OR merge block.
package cbm_pkg;

  localparam int WORD_W          = 32;
  localparam int CNT_W           = 27;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam logic [WORD_W-1:0] MSB_WORD  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] ONES_WORD = 32'hFFFF_FFFF;

  // input command codes
  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // class of a queued item
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_NOP   = 2'd2
  } kind_e;

  // decoded item passed from front to back
  typedef struct packed {
    kind_e              kind;
    logic               stream;
    logic               lit_valid;
    logic [WORD_W-1:0]  literal;
    logic               fill_value;
    logic [CNT_W-1:0]   fill_count;
  } item_t;

  // one result as presented on the output channel
  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [CNT_W-1:0]   count;
    logic [1:0]         want;
    logic               misuse;
    logic               last;
  } res_t;

  function automatic logic [WORD_W-1:0] fill_word(input logic value);
    return value ? ONES_WORD : MSB_WORD;
  endfunction

endpackage

FILE: hdl/cbm_front.sv
// Front end: takes input transfers, classifies the command and decodes the code word.
module cbm_front (
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic [cbm_pkg::WORD_W-1:0] code_word_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output cbm_pkg::item_t             push_item_o
);
  import cbm_pkg::*;

  logic [2:0]        len;
  logic [4:0]        len_x3;
  logic [4:0]        cbits;
  logic [4:0]        pos;
  logic [WORD_W-1:0] lit_mask;
  logic [WORD_W-1:0] cnt_mask;
  logic [WORD_W-1:0] lit_raw;
  logic [WORD_W-1:0] lit_shift;
  logic [WORD_W-1:0] cnt_bits;

  assign len       = code_word_i[29:27];
  assign len_x3    = {2'b00, len} + {1'b0, len, 1'b0};
  assign cbits     = 5'd23 - len_x3;
  assign lit_mask  = (32'h1 << len_x3) - 32'h1;
  assign cnt_mask  = (32'h1 << cbits) - 32'h1;
  assign lit_raw   = (code_word_i >> cbits) & lit_mask;
  assign pos       = {code_word_i[26:23], 1'b0};
  assign lit_shift = lit_raw << pos;
  assign cnt_bits  = code_word_i & cnt_mask;

  assign in_stall_o   = !push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    push_item_o        = '0;
    push_item_o.stream = cmd_i[0];
    unique case (cmd_i)
      CMD_LOAD_A, CMD_LOAD_B: push_item_o.kind = KIND_LOAD;
      CMD_CLEAR:              push_item_o.kind = KIND_CLEAR;
      default:                push_item_o.kind = KIND_NOP;
    endcase

    if (code_word_i[31]) begin
      // plain literal word, empty fill
      push_item_o.lit_valid = 1'b1;
      push_item_o.literal   = code_word_i;
    end else begin
      push_item_o.fill_value = code_word_i[30];
      if (len == 3'd0) begin
        push_item_o.fill_count = code_word_i[CNT_W-1:0];
      end else begin
        // dirty word ahead of a short fill
        push_item_o.lit_valid  = 1'b1;
        push_item_o.literal    = lit_shift | MSB_WORD;
        push_item_o.fill_count = cnt_bits[CNT_W-1:0];
      end
    end
  end

endmodule

FILE: hdl/cbm_queue.sv
// Short FIFO of decoded items between front end and back end.
module cbm_queue #(
  parameter int DEPTH = cbm_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  cbm_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output cbm_pkg::item_t pop_item_o
);
  import cbm_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic             push, pop;

  assign push_ready_o = occ_q != OCC_W'(DEPTH);
  assign pop_valid_o  = occ_q != '0;
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    occ_d = occ_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      occ_d = occ_q + 1'b1;
    end else if (pop && !push) begin
      occ_d = occ_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      occ_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

FILE: hdl/cbm_back.sv
// Back end: stream state, two-step merge per item and result buffer.
module cbm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_mode_i,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  cbm_pkg::item_t pop_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cbm_pkg::res_t  out_res_o
);
  import cbm_pkg::*;

  typedef enum logic [1:0] {
    ST_LIT  = 2'b01,
    ST_FILL = 2'b10
  } state_e;

  state_e state_q, state_d;

  // per-stream state, index 0 = A, 1 = B
  logic [1:0]             lv_q, lv_d;
  logic [1:0][WORD_W-1:0] lit_q, lit_d;
  logic [1:0]             fv_q, fv_d;
  logic [1:0][CNT_W-1:0]  fill_q, fill_d;
  logic [1:0]             exh;

  // item held between the two steps
  logic              pend_load_q, pend_load_d;
  logic              pend_misuse_q, pend_misuse_d;
  logic              lit_run_q, lit_run_d;
  logic [WORD_W-1:0] lit_word_q, lit_word_d;

  // result buffer
  res_t       buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d;
  logic       buf_free, buf_wr, out_xfer;
  res_t       res0, res1;
  logic [1:0] res_n;

  // step one signals
  logic                   is_load, do_load, misuse;
  logic [1:0]             l_lv, l_fv, l_exh;
  logic [1:0][WORD_W-1:0] l_lit, side;
  logic [1:0][CNT_W-1:0]  l_fill, s_fill;
  logic                   lstep;
  logic [WORD_W-1:0]      lit_word;

  // step two signals
  logic                  fstep, a_lt;
  logic [CNT_W:0]        diff_ab;
  logic [CNT_W-1:0]      diff_ba, run_cnt;
  logic [1:0][CNT_W-1:0] n_fill;
  logic [1:0]            want;
  logic [WORD_W-1:0]     fw_a, fw_b, fill_merged;
  res_t                  e_lit, e_fill, e_stat;

  for (genvar k = 0; k < 2; k++) begin : g_exh
    assign exh[k]   = !lv_q[k] && (fill_q[k] == '0);
    assign l_exh[k] = !l_lv[k] && (l_fill[k] == '0);
  end

  // load the decoded word, then one literal step if it applies
  always_comb begin
    is_load = pop_item_i.kind == KIND_LOAD;
    do_load = is_load && exh[pop_item_i.stream];
    misuse  = is_load && !exh[pop_item_i.stream];
    for (int k = 0; k < 2; k++) begin
      if (do_load && (pop_item_i.stream == 1'(k))) begin
        l_lv[k]   = pop_item_i.lit_valid;
        l_lit[k]  = pop_item_i.literal;
        l_fv[k]   = pop_item_i.fill_value;
        l_fill[k] = pop_item_i.fill_count;
      end else begin
        l_lv[k]   = lv_q[k];
        l_lit[k]  = lit_q[k];
        l_fv[k]   = fv_q[k];
        l_fill[k] = fill_q[k];
      end
    end
    lstep = do_load && !l_exh[0] && !l_exh[1] && (l_lv[0] || l_lv[1]);
    for (int k = 0; k < 2; k++) begin
      side[k]   = l_lv[k] ? l_lit[k] : fill_word(l_fv[k]);
      s_fill[k] = (lstep && !l_lv[k]) ? l_fill[k] - 1'b1 : l_fill[k];
    end
    lit_word = op_mode_i ? (side[0] | side[1]) : (side[0] & side[1]);
  end

  // fill step: both sides are pure fills here
  assign fstep   = (state_q == ST_FILL) && pend_load_q && !exh[0] && !exh[1];
  assign diff_ab = {1'b0, fill_q[0]} - {1'b0, fill_q[1]};
  assign diff_ba = fill_q[1] - fill_q[0];
  assign a_lt    = diff_ab[CNT_W];
  assign run_cnt = a_lt ? fill_q[0] : fill_q[1];
  assign fw_a    = fill_word(fv_q[0]);
  assign fw_b    = fill_word(fv_q[1]);
  assign fill_merged = op_mode_i ? (fw_a | fw_b) : (fw_a & fw_b);

  always_comb begin
    n_fill = fill_q;
    if (fstep) begin
      n_fill[0] = a_lt ? '0 : diff_ab[CNT_W-1:0];
      n_fill[1] = a_lt ? diff_ba : '0;
    end
    for (int k = 0; k < 2; k++) begin
      want[k] = !lv_q[k] && (n_fill[k] == '0);
    end

    e_lit.word   = lit_word_q;
    e_lit.count  = CNT_W'(1);
    e_lit.want   = want;
    e_lit.misuse = pend_misuse_q;
    e_lit.last   = !fstep;

    e_fill.word   = fill_merged;
    e_fill.count  = run_cnt;
    e_fill.want   = want;
    e_fill.misuse = pend_misuse_q;
    e_fill.last   = 1'b1;

    e_stat.word   = '0;
    e_stat.count  = '0;
    e_stat.want   = want;
    e_stat.misuse = pend_misuse_q;
    e_stat.last   = 1'b1;

    priority if (lit_run_q) begin
      res0 = e_lit;
    end else if (fstep) begin
      res0 = e_fill;
    end else begin
      res0 = e_stat;
    end
    res1  = e_fill;
    res_n = (lit_run_q && fstep) ? 2'd2 : 2'd1;
  end

  assign out_valid_o = cnt_q != 2'd0;
  assign out_res_o   = buf_q[rd_q];
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign buf_free    = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_xfer);
  assign pop_ready_o = state_q == ST_LIT;
  assign buf_wr      = (state_q == ST_FILL) && buf_free;

  always_comb begin
    state_d       = state_q;
    lv_d          = lv_q;
    lit_d         = lit_q;
    fv_d          = fv_q;
    fill_d        = fill_q;
    pend_load_d   = pend_load_q;
    pend_misuse_d = pend_misuse_q;
    lit_run_d     = lit_run_q;
    lit_word_d    = lit_word_q;
    unique case (state_q)
      ST_LIT: begin
        if (pop_valid_i) begin
          if (pop_item_i.kind == KIND_CLEAR) begin
            lv_d   = '0;
            lit_d  = '0;
            fv_d   = '0;
            fill_d = '0;
          end else begin
            lv_d   = lstep ? 2'b00 : l_lv;
            lit_d  = l_lit;
            fv_d   = l_fv;
            fill_d = s_fill;
          end
          pend_load_d   = do_load;
          pend_misuse_d = misuse;
          lit_run_d     = lstep;
          lit_word_d    = lit_word;
          state_d       = ST_FILL;
        end
      end
      ST_FILL: begin
        if (buf_free) begin
          fill_d  = n_fill;
          state_d = ST_LIT;
        end
      end
      default: state_d = ST_LIT;
    endcase

    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (buf_wr) begin
      cnt_d = res_n;
      rd_d  = 1'b0;
    end else if (out_xfer) begin
      cnt_d = cnt_q - 1'b1;
      rd_d  = !rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_LIT;
      lv_q          <= '0;
      lit_q         <= '0;
      fv_q          <= '0;
      fill_q        <= '0;
      pend_load_q   <= 1'b0;
      pend_misuse_q <= 1'b0;
      lit_run_q     <= 1'b0;
      cnt_q         <= '0;
      rd_q          <= 1'b0;
    end else begin
      state_q       <= state_d;
      lv_q          <= lv_d;
      lit_q         <= lit_d;
      fv_q          <= fv_d;
      fill_q        <= fill_d;
      pend_load_q   <= pend_load_d;
      pend_misuse_q <= pend_misuse_d;
      lit_run_q     <= lit_run_d;
      cnt_q         <= cnt_d;
      rd_q          <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lit_word_q <= lit_word_d;
    if (buf_wr) begin
      buf_q[0] <= res0;
      buf_q[1] <= res1;
    end
  end

  a_fill_no_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstep |-> (!lv_q[0] && !lv_q[1]))
    else $error("fill step with a literal still pending");

  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("result buffer count out of range");

  a_tail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> out_res_o.last)
    else $error("final buffered result not flagged last");

  a_pop_to_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid_i && pop_ready_o) |=> (state_q == ST_FILL))
    else $error("no fill step after item pop");

endmodule

FILE: hdl/compressed_bitmap_and_or_merge_top.sv
// Top level: merge of two compressed bitmap streams by AND or OR.
// An accepted item is queued, then taken by the back end's literal step and fill step on the
// shared stream state; the back end takes a new item only after the fill step of the last one.
// Each item gives one or two results, one per cycle while the receiver does not stall.
// The queue lets items be taken while results wait to be transferred.
// Reset clears op_mode, both streams' state, the item queue and the result buffer.
module compressed_bitmap_and_or_merge_top #(
  parameter int QUEUE_DEPTH = cbm_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic [cbm_pkg::WORD_W-1:0] code_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [cbm_pkg::WORD_W-1:0] result_word_o,
  output logic [cbm_pkg::CNT_W-1:0]  repeat_count_o,
  output logic [1:0]                 want_streams_o,
  output logic                       misuse_error_o,
  output logic                       last_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_op_mode_i
);
  import cbm_pkg::*;

  logic  op_mode_q;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;
  res_t  out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      op_mode_q <= cfg_op_mode_i;
    end
  end

  cbm_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .code_word_i  (code_word_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  cbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  cbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_mode_i   (op_mode_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign result_word_o  = out_res.word;
  assign repeat_count_o = out_res.count;
  assign want_streams_o = out_res.want;
  assign misuse_error_o = out_res.misuse;
  assign last_o         = out_res.last;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the compressed bitmap AND/OR merge block.
module testbench;
  import cbm_pkg::*;

  localparam logic [1:0] CMD_SPARE  = 2'd3;   // undefined command code
  localparam logic       MODE_AND   = 1'b0;
  localparam logic       MODE_OR    = 1'b1;
  localparam int         IDLE_LIMIT = 2000;
  localparam int         DRAIN_WAIT = 10;
  localparam int         MAX_RUNS   = 4;
  localparam int         REPORT_MAX = 10;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        cmd;
  logic [WORD_W-1:0] code_word;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] result_word;
  logic [CNT_W-1:0]  repeat_count;
  logic [1:0]        want_streams;
  logic              misuse_error;
  logic              last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_op_mode;

  compressed_bitmap_and_or_merge_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .code_word_i    (code_word),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_word_o  (result_word),
    .repeat_count_o (repeat_count),
    .want_streams_o (want_streams),
    .misuse_error_o (misuse_error),
    .last_o         (last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_op_mode_i  (cfg_op_mode)
  );

  always #1 clk_i = ~clk_i;

  // predicted stream state, index 0 = A, 1 = B
  logic              and_or_mode = MODE_AND;
  logic [WORD_W-1:0] lit_word[2]    = '{default: '0};
  logic              lit_pending[2] = '{default: 1'b0};
  logic              fill_bit[2]    = '{default: 1'b0};
  logic [CNT_W-1:0]  fill_left[2]   = '{default: '0};

  res_t pending_runs[$];

  int  mismatches    = 0;
  int  items_sent    = 0;
  int  runs_checked  = 0;
  int  clears_sent   = 0;
  int  misuse_seen   = 0;
  int  mode_writes   = 0;
  int  idle_cycles   = 0;
  int  stall_hold    = 0;
  bit  no_idle       = 1'b0;

  function automatic logic stream_empty(int s);
    return !lit_pending[s] && fill_left[s] == '0;
  endfunction

  function automatic logic [WORD_W-1:0] fill_pattern(int s);
    return fill_bit[s] ? ONES_WORD : MSB_WORD;
  endfunction

  function automatic logic [WORD_W-1:0] take_word(int s);
    if (lit_pending[s]) begin
      lit_pending[s] = 1'b0;
      return lit_word[s];
    end
    fill_left[s] = fill_left[s] - 1'b1;
    return fill_pattern(s);
  endfunction

  function automatic logic [WORD_W-1:0] merge_bits(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    return and_or_mode ? (a | b) : (a & b);
  endfunction

  // decode one code word into a stream's literal and fill run
  task automatic load_stream(int s, logic [WORD_W-1:0] w);
    int                len;
    int                cbits;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] lit;
    if (w[31]) begin
      lit_word[s]    = w;
      lit_pending[s] = 1'b1;
      fill_left[s]   = '0;
      fill_bit[s]    = 1'b0;
    end else begin
      fill_bit[s] = w[30];
      len = w[29:27];
      if (len == 0) begin
        fill_left[s]   = w[CNT_W-1:0];
        lit_pending[s] = 1'b0;
        lit_word[s]    = '0;
      end else begin
        cbits = 23 - 3 * len;
        mask  = (32'd1 << cbits) - 32'd1;
        lit   = (w >> cbits) & ((32'd1 << (3 * len)) - 32'd1);
        fill_left[s]   = w[CNT_W-1:0] & mask[CNT_W-1:0];
        lit_word[s]    = (lit << (2 * w[26:23])) | MSB_WORD;
        lit_pending[s] = 1'b1;
      end
    end
  endtask

  // work out the runs one accepted item gives and queue them
  task automatic merge_predict(logic [1:0] c, logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] words[MAX_RUNS];
    logic [CNT_W-1:0]  counts[MAX_RUNS];
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [CNT_W-1:0]  span;
    logic              misuse;
    int                n;
    int                s;
    res_t              r;
    misuse = 1'b0;
    n = 0;
    case (c)
      CMD_CLEAR: begin
        for (int i = 0; i < 2; i++) begin
          lit_word[i]    = '0;
          lit_pending[i] = 1'b0;
          fill_bit[i]    = 1'b0;
          fill_left[i]   = '0;
        end
        clears_sent++;
      end
      CMD_LOAD_A, CMD_LOAD_B: begin
        s = (c == CMD_LOAD_B) ? 1 : 0;
        if (!stream_empty(s)) begin
          misuse = 1'b1;
          misuse_seen++;
        end else begin
          load_stream(s, w);
          while (n < MAX_RUNS && !stream_empty(0) && !stream_empty(1)) begin
            if (lit_pending[0] || lit_pending[1]) begin
              a = take_word(0);
              b = take_word(1);
              words[n]  = merge_bits(a, b);
              counts[n] = CNT_W'(1);
            end else begin
              span = (fill_left[0] < fill_left[1]) ? fill_left[0] : fill_left[1];
              words[n]  = merge_bits(fill_pattern(0), fill_pattern(1));
              counts[n] = span;
              fill_left[0] = fill_left[0] - span;
              fill_left[1] = fill_left[1] - span;
            end
            n++;
          end
        end
      end
      default: ;
    endcase
    if (n == 0) begin
      words[0]  = '0;
      counts[0] = '0;
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      r.word   = words[k];
      r.count  = counts[k];
      r.want   = {stream_empty(1), stream_empty(0)};
      r.misuse = misuse;
      r.last   = (k == n - 1);
      pending_runs.push_back(r);
    end
  endtask

  // one item transfer; valid is left high so a following item can go straight on
  task automatic send_item(logic [1:0] c, logic [WORD_W-1:0] w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) @(negedge clk_i) in_valid <= 1'b0;
    @(negedge clk_i);
    in_valid  <= 1'b1;
    cmd       <= c;
    code_word <= w;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    merge_predict(c, w);
  endtask

  task automatic wait_drained();
    @(negedge clk_i) in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_op_mode(logic m);
    wait_drained();
    @(negedge clk_i);
    cfg_valid   <= 1'b1;
    cfg_op_mode <= m;
    do @(posedge clk_i); while (!cfg_ready);
    and_or_mode = m;
    mode_writes++;
    @(negedge clk_i) cfg_valid <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] dirty_word(logic val, int len, int pos,
                                                   logic [WORD_W-1:0] lit,
                                                   logic [WORD_W-1:0] cnt);
    int                cbits;
    logic [WORD_W-1:0] w;
    cbits = 23 - 3 * len;
    w = {1'b0, val, len[2:0], pos[3:0], 23'd0};
    w |= (lit & ((32'd1 << (3 * len)) - 32'd1)) << cbits;
    w |= cnt & ((32'd1 << cbits) - 32'd1);
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] random_code_word();
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] mask;
    int                len;
    w = $urandom();
    len = $urandom_range(1, 7);
    mask = (32'd1 << (23 - 3 * len)) - 32'd1;
    case ($urandom_range(0, 9))
      0, 1, 2: w[31] = 1'b1;
      3, 4: begin
        w[31] = 1'b0;
        w[29:27] = 3'd0;
        w[CNT_W-1:0] = CNT_W'($urandom_range(1, 40));
      end
      5: begin
        w[31] = 1'b0;
        w[29:27] = 3'd0;
      end
      6: begin
        // empty fill, with or without a dirty word ahead of it
        w[31] = 1'b0;
        if ($urandom_range(0, 1)) begin
          w[29:27] = 3'd0;
          w[CNT_W-1:0] = '0;
        end else begin
          w[29:27] = len[2:0];
          w = w & ~mask;
        end
      end
      default: begin
        w[31] = 1'b0;
        w[29:27] = len[2:0];
        if ($urandom_range(0, 1)) w = (w & ~mask) | ($urandom_range(0, 3) & mask);
      end
    endcase
    return w;
  endfunction

  task automatic test_directed_merge(logic m);
    set_op_mode(m);
    send_item(CMD_LOAD_A, MSB_WORD);
    send_item(CMD_LOAD_B, ONES_WORD);
    send_item(CMD_LOAD_A, 32'h47FF_FFFF);             // all-ones fill, largest count
    send_item(CMD_LOAD_B, 32'h0000_0005);
    send_item(CMD_LOAD_A, 32'hFFFF_FFFF);             // A still busy: rejected
    send_item(CMD_LOAD_B, 32'h0000_0000);             // fill of length zero
    send_item(CMD_LOAD_B, dirty_word(1'b1, 7, 15, 32'h001F_FFFF, 3));
    send_item(CMD_LOAD_B, dirty_word(1'b0, 1, 0, 32'd7, 0));
    send_item(CMD_CLEAR, 32'h1234_5678);
    send_item(CMD_LOAD_A, dirty_word(1'b0, 3, 5, 32'h1A5, 1));
    send_item(CMD_LOAD_B, 32'hDEAD_BEEF);
    send_item(CMD_LOAD_B, 32'h4000_0001);
    send_item(CMD_SPARE, ONES_WORD);
  endtask

  // mostly well-formed feeding of whichever stream asks, with some misuse and noise
  task automatic test_random_merge(int n_items, logic m);
    int useful;
    int pick;
    int s;
    set_op_mode(m);
    useful = 0;
    while (useful < n_items) begin
      no_idle = (useful < 20);
      if (useful == n_items / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (stream_empty(0) && stream_empty(1)) s = $urandom_range(0, 1);
      else s = stream_empty(0) ? 0 : 1;
      if (pick < 82) begin
        send_item(s ? CMD_LOAD_B : CMD_LOAD_A, random_code_word());
        useful++;
      end else if (pick < 91) begin
        if (!stream_empty(1 - s)) s = 1 - s;
        send_item(s ? CMD_LOAD_B : CMD_LOAD_A, random_code_word());
        if (!pending_runs[$].misuse) useful++;
      end else if (pick < 96) begin
        send_item(CMD_CLEAR, $urandom());
        useful++;
      end else begin
        send_item(CMD_SPARE, $urandom());
      end
    end
    no_idle = 1'b0;
  endtask

  // result check
  always @(posedge clk_i) begin
    res_t exp_run;
    if (rst_ni && out_valid && !out_stall) begin
      stall_hold = no_idle ? 0 : $urandom_range(0, 3);
      runs_checked++;
      if (pending_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: word %h count %0d want %b misuse %b last %b",
                   result_word, repeat_count, want_streams, misuse_error, last);
      end else begin
        exp_run = pending_runs.pop_front();
        if (result_word !== exp_run.word || repeat_count !== exp_run.count ||
            want_streams !== exp_run.want || misuse_error !== exp_run.misuse ||
            last !== exp_run.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: exp word %h count %0d want %b misuse %b last %b / got %h %0d %b %b %b",
                     exp_run.word, exp_run.count, exp_run.want, exp_run.misuse,
                     exp_run.last, result_word, repeat_count, want_streams,
                     misuse_error, last);
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold = stall_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles with no transfer", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    cmd         = CMD_LOAD_A;
    code_word   = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_op_mode = MODE_AND;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_directed_merge(MODE_AND);
    test_directed_merge(MODE_OR);
    test_random_merge(90, MODE_OR);
    test_random_merge(90, MODE_AND);
    test_random_merge(90, MODE_OR);
    test_random_merge(90, MODE_AND);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_runs.size() != 0) mismatches++;

    $display("covered %0d items (%0d clears, %0d rejected words), %0d runs checked",
             items_sent, clears_sent, misuse_seen, runs_checked);
    $display("op_mode written %0d times, AND and OR phases alternated; %0d mismatches",
             mode_writes, mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: compressed_bitmap_and_or_merge_top.f
hdl/cbm_pkg.sv
hdl/cbm_front.sv
hdl/cbm_queue.sv
hdl/cbm_back.sv
hdl/compressed_bitmap_and_or_merge_top.sv
tb/testbench.sv
